FILE: rtl/core/tbk_pkg.sv
// ----------------------------------------------------------------------------
// tbk_pkg: shared types and constants for the top/bottom three selector
// Field widths, list entry layout and list kind codes.
// ----------------------------------------------------------------------------
package tbk_pkg;

   localparam int CODE_W   = 31;
   localparam int PRICE_W  = 32;
   localparam int RANK_W   = 2;
   localparam int KEEP_DEF = 3;

   // list kind codes carried in list_kind
   localparam logic LIST_HIGH = 1'b0;
   localparam logic LIST_LOW  = 1'b1;

   typedef struct packed {
      logic [CODE_W-1:0]  code;
      logic [PRICE_W-1:0] price;
   } entry_type;

endpackage

FILE: rtl/core/tbk_if.sv
// ----------------------------------------------------------------------------
// tbk_req_if / tbk_rsp_if: valid/ready channels of the selector
// Item channel carries one (code, price) pair; result channel one ranked slot.
// ----------------------------------------------------------------------------
interface tbk_req_if;
   import tbk_pkg::*;
   logic               valid;
   logic               ready;
   logic [CODE_W-1:0]  item_code;
   logic [PRICE_W-1:0] item_price;
   logic               set_end;

   modport source (output valid, item_code, item_price, set_end, input ready);
   modport sink   (input valid, item_code, item_price, set_end, output ready);
endinterface

interface tbk_rsp_if;
   import tbk_pkg::*;
   logic               valid;
   logic               ready;
   logic               list_kind;
   logic [RANK_W-1:0]  rank;
   logic [CODE_W-1:0]  out_code;
   logic [PRICE_W-1:0] out_price;
   logic               slot_valid;
   logic               final_result;

   modport source (output valid, list_kind, rank, out_code, out_price, slot_valid,
                   final_result, input ready);
   modport sink   (input valid, list_kind, rank, out_code, out_price, slot_valid,
                   final_result, output ready);
endinterface

FILE: rtl/core/tbk_insert.sv
// ----------------------------------------------------------------------------
// tbk_insert: stable compare-and-insert into one sorted list
// Places a new entry after all filled entries that stay ahead of it.
// ----------------------------------------------------------------------------
module tbk_insert
   import tbk_pkg::*;
#(
   parameter int KEEP      = KEEP_DEF,
   parameter bit WANT_HIGH = 1'b1,
   localparam int CNT_W    = $clog2(KEEP + 1)
) (
   input  entry_type [KEEP-1:0] list_cur,
   input  logic [CNT_W-1:0]     count,
   input  entry_type            item,
   output entry_type [KEEP-1:0] list_nxt
);

   logic [KEEP-1:0] ahead;

   // flag filled slots that keep their place (equal keys stay ahead)
   always_comb begin
      for (int k = 0; k < KEEP; k++) begin
         if (WANT_HIGH) begin
            ahead[k] = (CNT_W'(k) < count) && (list_cur[k].price >= item.price);
         end else begin
            ahead[k] = (CNT_W'(k) < count) && (list_cur[k].price <= item.price);
         end
      end
   end

   // keep, insert or shift down by one
   always_comb begin
      for (int k = 0; k < KEEP; k++) begin
         if (ahead[k]) begin
            list_nxt[k] = list_cur[k];
         end else if (k == 0) begin
            list_nxt[k] = item;
         end else if (ahead[k-1]) begin
            list_nxt[k] = item;
         end else begin
            list_nxt[k] = list_cur[k-1];
         end
      end
   end

endmodule

FILE: rtl/core/top_bottom_three_by_key_core.sv
// Throughput: one item per cycle unless a set_end waits; both lists update at once.
// Results start the cycle after the set_end transfer, six per burst.
// A set_end item waits only while an earlier burst is still draining.
// Burst length is 2*KEEP results, one per rsp transfer.
// Reset: lists empty, fill count zero, no result pending.
// ----------------------------------------------------------------------------
// top_bottom_three_by_key_core: running top-KEEP / bottom-KEEP selector
// Keeps the highest and lowest priced pairs of a set and emits both lists
// when the last item of the set arrives.
// ----------------------------------------------------------------------------
module top_bottom_three_by_key_core
   import tbk_pkg::*;
#(
   parameter int KEEP = KEEP_DEF
) (
   input logic       clock,
   input logic       reset,
   tbk_req_if.sink   req_bus,
   tbk_rsp_if.source rsp_bus
);

   localparam int CNT_W = $clog2(KEEP + 1);
   localparam int NOUT  = 2 * KEEP;
   localparam int IDX_W = (NOUT > 1) ? $clog2(NOUT) : 1;

   entry_type [KEEP-1:0] high_ff, low_ff;
   entry_type [KEEP-1:0] high_in, low_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   entry_type [NOUT-1:0] snap_ff;
   logic [CNT_W-1:0]     snap_cnt_ff;
   logic                 busy_ff;
   logic [IDX_W-1:0]     idx_ff;

   entry_type            item;
   logic                 req_xfer, rsp_xfer, last_out;
   logic                 is_low;
   logic [IDX_W-1:0]     slot;
   entry_type            cur;

   assign item.code  = req_bus.item_code;
   assign item.price = req_bus.item_price;

   tbk_insert #(.KEEP(KEEP), .WANT_HIGH(1'b1)) u_high (
      .list_cur (high_ff),
      .count    (cnt_ff),
      .item     (item),
      .list_nxt (high_in)
   );

   tbk_insert #(.KEEP(KEEP), .WANT_HIGH(1'b0)) u_low (
      .list_cur (low_ff),
      .count    (cnt_ff),
      .item     (item),
      .list_nxt (low_in)
   );

   // saturate fill count at KEEP
   assign cnt_in = (cnt_ff == CNT_W'(KEEP)) ? cnt_ff : cnt_ff + 1'b1;

   // handshake: a set end needs the output burst free or just finishing
   assign rsp_xfer      = busy_ff && rsp_bus.ready;
   assign last_out      = (idx_ff == IDX_W'(NOUT - 1));
   assign req_bus.ready = !busy_ff || !req_bus.set_end || (rsp_xfer && last_out);
   assign req_xfer      = req_bus.valid && req_bus.ready;

   // update lists, start a burst on set end, advance the output index
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (req_xfer && req_bus.set_end) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b1;
         idx_ff  <= '0;
      end else begin
         if (req_xfer) begin
            cnt_ff <= cnt_in;
         end
         if (rsp_xfer) begin
            if (last_out) begin
               busy_ff <= 1'b0;
               idx_ff  <= '0;
            end else begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         high_ff <= high_in;
         low_ff  <= low_in;
         if (req_bus.set_end) begin
            snap_ff     <= {low_in, high_in};
            snap_cnt_ff <= cnt_in;
         end
      end
   end

   // select the current result slot
   assign is_low = (idx_ff >= IDX_W'(KEEP));
   assign slot   = is_low ? idx_ff - IDX_W'(KEEP) : idx_ff;
   assign cur    = snap_ff[idx_ff];

   assign rsp_bus.valid        = busy_ff;
   assign rsp_bus.list_kind    = is_low ? LIST_LOW : LIST_HIGH;
   assign rsp_bus.rank         = RANK_W'(slot);
   assign rsp_bus.slot_valid   = ({{(CNT_W > IDX_W ? CNT_W - IDX_W : 0){1'b0}}, slot}
                                  < {{(IDX_W > CNT_W ? IDX_W - CNT_W : 0){1'b0}},
                                     snap_cnt_ff});
   assign rsp_bus.out_code     = rsp_bus.slot_valid ? cur.code : '0;
   assign rsp_bus.out_price    = rsp_bus.slot_valid ? cur.price : '0;
   assign rsp_bus.final_result = last_out;

endmodule

FILE: rtl/core/tbk_checker.sv
// ----------------------------------------------------------------------------
// tbk_checker: port-level checks of the selector
// Watches both channels and flags burst framing and payload slips.
// ----------------------------------------------------------------------------
module tbk_checker
   import tbk_pkg::*;
#(
   parameter int KEEP = KEEP_DEF
) (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_set_end,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_list_kind,
   input logic [RANK_W-1:0]  rsp_rank,
   input logic [CODE_W-1:0]  rsp_out_code,
   input logic [PRICE_W-1:0] rsp_out_price,
   input logic               rsp_slot_valid,
   input logic               rsp_final_result
);

   logic set_end_xfer, final_xfer;

   assign set_end_xfer = req_valid && req_ready && req_set_end;
   assign final_xfer   = rsp_valid && rsp_ready && rsp_final_result;

   // a set end taken while idle starts a burst next cycle
   a_burst_start: assert property (@(posedge clock) disable iff (reset)
      set_end_xfer && !rsp_valid |=> rsp_valid)
      else $error("burst did not start after set end");

   // the burst stops after its final transfer unless a new set ended
   a_burst_stop: assert property (@(posedge clock) disable iff (reset)
      final_xfer |=> !rsp_valid || $past(set_end_xfer))
      else $error("result valid after final transfer");

   // the final result is the last rank of the low list
   a_final_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_final_result |->
         rsp_list_kind == LIST_LOW && rsp_rank == RANK_W'(KEEP - 1))
      else $error("final flag on wrong slot");

   // an empty slot carries zero payload
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_slot_valid |-> rsp_out_code == '0 && rsp_out_price == '0)
      else $error("empty slot with nonzero payload");

endmodule

bind top_bottom_three_by_key_core tbk_checker #(.KEEP(KEEP)) u_tbk_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .req_set_end      (req_bus.set_end),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_list_kind    (rsp_bus.list_kind),
   .rsp_rank         (rsp_bus.rank),
   .rsp_out_code     (rsp_bus.out_code),
   .rsp_out_price    (rsp_bus.out_price),
   .rsp_slot_valid   (rsp_bus.slot_valid),
   .rsp_final_result (rsp_bus.final_result)
);

FILE: dv/tb_top_bottom_three_by_key_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top_bottom_three_by_key_core: self-checking bench for the top/bottom
// three selector
// Sends sets of (code, price) items with random gaps and result stalls. A
// local scoreboard keeps its own high and low lists, queues the six ranked
// slots that each set end must produce and checks every result transfer in
// order.
// ----------------------------------------------------------------------------
module tb_top_bottom_three_by_key_core;
   import tbk_pkg::*;

   localparam int KEEP_N       = KEEP_DEF;
   localparam int RANDOM_ITEMS = 95;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_CYCLES = 16;

   typedef entry_type [KEEP_N-1:0] ranked_list_type;

   typedef struct packed {
      logic               list_kind;
      logic [RANK_W-1:0]  rank;
      logic [CODE_W-1:0]  code;
      logic [PRICE_W-1:0] price;
      logic               slot_valid;
      logic               final_result;
   } slot_result_type;

   logic clock = 1'b0;
   logic reset;

   tbk_req_if req_bus ();
   tbk_rsp_if rsp_bus ();

   top_bottom_three_by_key_core uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // scoreboard copy of the selector state
   ranked_list_type priciest;
   ranked_list_type cheapest;
   int              held_count;
   slot_result_type pending_slots[$];
   slot_result_type head_slot;

   // idle controls, shared by the tests and the result sink
   bit sender_idle_on;
   bit sink_stall_on;
   int stall_left;

   int cycle_count;
   int error_count;
   int items_sent;
   int sets_sent;
   int slots_checked;

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[top_bottom_three_by_key_core] ERROR");
         $finish;
      end
   end

   // random gap length: mostly short, a few long
   function automatic int pick_idle_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // insert one entry behind all entries of equal price
   function automatic ranked_list_type ranked_insert(ranked_list_type lst, int count,
                                                     bit want_high, entry_type e);
      int pos;
      bit scanning;
      bit ahead;
      pos = 0;
      scanning = 1'b1;
      for (int i = 0; i < count && i < KEEP_N; i++) begin
         ahead = want_high ? (lst[i].price >= e.price) : (lst[i].price <= e.price);
         if (scanning && ahead) pos++;
         else scanning = 1'b0;
      end
      if (pos < KEEP_N) begin
         for (int k = KEEP_N - 1; k > pos; k--) lst[k] = lst[k-1];
         lst[pos] = e;
      end
      return lst;
   endfunction

   // update the lists for one accepted item; queue the burst on a set end
   function automatic void select_and_rank(logic [CODE_W-1:0] code,
                                           logic [PRICE_W-1:0] price, logic last);
      entry_type       e;
      slot_result_type s;
      int              cnt;
      e.code  = code;
      e.price = price;
      cnt = held_count;
      priciest = ranked_insert(priciest, cnt, 1'b1, e);
      cheapest = ranked_insert(cheapest, cnt, 1'b0, e);
      if (cnt < KEEP_N) cnt++;
      held_count = cnt;
      items_sent++;
      if (last) begin
         for (int kind = 0; kind < 2; kind++) begin
            for (int r = 0; r < KEEP_N; r++) begin
               e = (kind == 0) ? priciest[r] : cheapest[r];
               s.list_kind    = (kind == 0) ? LIST_HIGH : LIST_LOW;
               s.rank         = r[RANK_W-1:0];
               s.slot_valid   = (r < cnt);
               s.code         = s.slot_valid ? e.code : '0;
               s.price        = s.slot_valid ? e.price : '0;
               s.final_result = (kind == 1 && r == KEEP_N - 1);
               pending_slots.push_back(s);
            end
         end
         priciest   = '0;
         cheapest   = '0;
         held_count = 0;
         sets_sent++;
      end
   endfunction

   // drive result ready with random stall stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (sink_stall_on && $urandom_range(0, 99) < 25) stall_left = pick_idle_len();
      end
   end

   // check each result transfer against the oldest queued slot
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_slots.size() == 0) begin
            $error("result transfer with nothing expected: kind %0d rank %0d",
                   rsp_bus.list_kind, rsp_bus.rank);
            error_count++;
         end else begin
            head_slot = pending_slots.pop_front();
            slots_checked++;
            if (rsp_bus.list_kind !== head_slot.list_kind) begin
               $error("list_kind: expected %0d, got %0d", head_slot.list_kind,
                      rsp_bus.list_kind);
               error_count++;
            end
            if (rsp_bus.rank !== head_slot.rank) begin
               $error("rank: expected %0d, got %0d", head_slot.rank, rsp_bus.rank);
               error_count++;
            end
            if (rsp_bus.out_code !== head_slot.code) begin
               $error("out_code: expected 0x%08h, got 0x%08h", head_slot.code,
                      rsp_bus.out_code);
               error_count++;
            end
            if (rsp_bus.out_price !== head_slot.price) begin
               $error("out_price: expected 0x%08h, got 0x%08h", head_slot.price,
                      rsp_bus.out_price);
               error_count++;
            end
            if (rsp_bus.slot_valid !== head_slot.slot_valid) begin
               $error("slot_valid: expected %0d, got %0d", head_slot.slot_valid,
                      rsp_bus.slot_valid);
               error_count++;
            end
            if (rsp_bus.final_result !== head_slot.final_result) begin
               $error("final_result: expected %0d, got %0d", head_slot.final_result,
                      rsp_bus.final_result);
               error_count++;
            end
         end
      end
   end

   // send one item; called at a rising edge, returns at its transfer edge
   task automatic send_item(input logic [CODE_W-1:0] code,
                            input logic [PRICE_W-1:0] price, input logic last);
      int gap;
      gap = 0;
      if (sender_idle_on && $urandom_range(0, 99) < 40) gap = pick_idle_len();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.item_code  <= code;
      req_bus.item_price <= price;
      req_bus.set_end    <= last;
      do @(posedge clock); while (!req_bus.ready);
      select_and_rank(code, price, last);
   endtask

   // hold until every queued slot has been seen
   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      while (pending_slots.size() != 0) @(posedge clock);
   endtask

   // one item set: only rank 0 of each list is filled
   task automatic test_lone_item();
      send_item(31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
   endtask

   // two item set: rank 2 stays empty
   task automatic test_short_set();
      send_item(31'h0000_0000, 32'h0000_0000, 1'b0);
      send_item(31'h5555_5555, 32'hAAAA_AAAA, 1'b1);
   endtask

   // equal prices keep arrival order in both lists
   task automatic test_equal_prices();
      for (int i = 1; i <= 4; i++) send_item(CODE_W'(i), 32'h0001_8000, i == 4);
   endtask

   // price and code extremes in one set, more items than slots
   task automatic test_field_extremes();
      send_item(31'h0000_0000, 32'hFFFF_FFFF, 1'b0);
      send_item(31'h7FFF_FFFF, 32'h0000_0000, 1'b0);
      send_item(31'h2AAA_AAAA, 32'h5555_5555, 1'b0);
      send_item(31'h0000_0001, 32'h0000_0001, 1'b0);
      send_item(31'h5555_5555, 32'hFFFF_FFFE, 1'b1);
   endtask

   // set ends arrive while earlier bursts are still draining
   task automatic test_back_to_back_sets();
      sender_idle_on = 1'b0;
      sink_stall_on  = 1'b0;
      send_item(CODE_W'($urandom), $urandom, 1'b1);
      send_item(CODE_W'($urandom), $urandom, 1'b1);
      sink_stall_on = 1'b1;
      send_item(CODE_W'($urandom), $urandom, 1'b0);
      send_item(CODE_W'($urandom), $urandom, 1'b1);
      send_item(CODE_W'($urandom), $urandom, 1'b1);
   endtask

   // let the result queue empty completely, then start a new set
   task automatic test_drain_pause();
      sender_idle_on = 1'b1;
      send_item(CODE_W'($urandom), 32'h0000_0010, 1'b0);
      send_item(CODE_W'($urandom), 32'h0000_0010, 1'b0);
      send_item(CODE_W'($urandom), 32'h0000_0020, 1'b1);
      wait_for_results();
      send_item(CODE_W'($urandom), 32'h8000_0000, 1'b1);
   endtask

   // random sets of random size, with tie-heavy price patterns
   task automatic test_random_sets();
      int done;
      int size;
      int roll;
      int mode;
      logic [PRICE_W-1:0] base;
      logic [PRICE_W-1:0] price;
      done = 0;
      while (done < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 9);
         if (roll < 6) size = $urandom_range(1, 5);
         else if (roll < 9) size = $urandom_range(6, 10);
         else size = $urandom_range(11, 20);
         mode = $urandom_range(0, 3);
         base = $urandom;
         sender_idle_on = ($urandom_range(0, 3) != 0);
         sink_stall_on  = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < size; i++) begin
            case (mode)
               0:       price = $urandom;
               1:       price = $urandom_range(0, 3);
               2:       price = 32'hFFFF_FFFF - $urandom_range(0, 3);
               default: price = base + $urandom_range(0, 2);
            endcase
            send_item(CODE_W'($urandom), price, i == size - 1);
            done++;
         end
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.item_code  = '0;
      req_bus.item_price = '0;
      req_bus.set_end    = 1'b0;
      priciest           = '0;
      cheapest           = '0;
      held_count         = 0;
      sender_idle_on     = 1'b1;
      sink_stall_on      = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_lone_item();
      test_short_set();
      test_equal_prices();
      test_field_extremes();
      test_back_to_back_sets();
      test_drain_pause();
      test_random_sets();

      // drain, then watch for stray results
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d items in %0d sets (short sets, ties, extremes, random gaps).",
               items_sent, sets_sent);
      $display("Checked %0d ranked slots field by field, %0d mismatches.",
               slots_checked, error_count);
      if (error_count == 0) begin
         $display("[top_bottom_three_by_key_core] OK");
      end else begin
         $display("[top_bottom_three_by_key_core] ERROR");
      end
      $finish;
   end

endmodule

FILE: top_bottom_three_by_key_core.f
rtl/core/tbk_pkg.sv
rtl/core/tbk_if.sv
rtl/core/tbk_insert.sv
rtl/core/top_bottom_three_by_key_core.sv
rtl/core/tbk_checker.sv
dv/tb_top_bottom_three_by_key_core.sv
